>>> design/tfpf_pkg.sv
// Shared types, constants and coefficient lookup for the temporal FIR pixel filter.
package tfpf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int FRAC_W         = 15;
    localparam int FP_W           = 11;
    localparam int FP_RESET       = 1024;
    localparam int TAPS_DEF       = 20;
    localparam int MAX_PIXELS_DEF = 1024;
    localparam int HALF_LEN       = 10;
    localparam int GRP            = 4;

    // Bit positions of the result flags in m_axis_tuser
    localparam int USER_FULL_BIT  = 0;
    localparam int USER_CLIP_BIT  = 1;
    localparam int USER_W         = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    // Q1.15 half of the symmetric impulse response
    localparam coef_t HALF_COEF [HALF_LEN] = '{
        16'sd331, -16'sd174, -16'sd1003, -16'sd524, 16'sd2100,
        16'sd2920, -16'sd1429, -16'sd5521, -16'sd1914, 16'sd5295
    };

    // Coefficient of tap k (k frames ago), mirrored about the center
    function automatic coef_t coef_at(input int k, input int taps);
        int m;
        m = taps - 1 - k;
        if (k < m) begin
            m = k;
        end
        if (m < HALF_LEN) begin
            return HALF_COEF[m];
        end
        return '0;
    endfunction

endpackage

>>> design/tfpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/tfpf_store.sv
// Per-pixel history store: one RAM per past frame, clearing sweep and write-to-read bypass.
module tfpf_store #(
    parameter int TAPS       = 20,
    parameter int MAX_PIXELS = 1024,
    localparam int HIST  = TAPS - 1,
    localparam int POS_W = $clog2(MAX_PIXELS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [POS_W-1:0]  rd_addr,
    input  logic              wr_en,
    input  logic [POS_W-1:0]  wr_addr,
    input  tfpf_pkg::sample_t wr_sample,
    output tfpf_pkg::sample_t hist [HIST],
    output logic              busy
);
    import tfpf_pkg::*;

    logic             clr_active_reg;
    logic [POS_W-1:0] clr_addr_reg;
    logic             fwd_reg;
    sample_t          fwd_hist_reg [HIST];
    sample_t          wr_hist [HIST];
    logic [SAMPLE_W-1:0] rd_data [HIST];

    // Sweep every position once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + POS_W'(1);
            if (clr_addr_reg == POS_W'(MAX_PIXELS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Shift this pixel's history: newest sample into entry zero
    always_comb begin
        wr_hist[0] = wr_sample;
        for (int j = 1; j < HIST; j++) begin
            wr_hist[j] = hist[j-1];
        end
    end

    // A read that lands on the same edge as the write of the same position sees old data;
    // hold the written history and use it instead
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_hist_reg <= wr_hist;
        end
    end

    for (genvar j = 0; j < HIST; j++) begin : g_tap
        tfpf_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (MAX_PIXELS)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (clr_active_reg || wr_en),
            .wr_addr (clr_active_reg ? clr_addr_reg : wr_addr),
            .wr_data (clr_active_reg ? '0 : wr_hist[j]),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (rd_data[j])
        );

        assign hist[j] = fwd_reg ? fwd_hist_reg[j] : rd_data[j];
    end

    assign busy = clr_active_reg;

endmodule

>>> design/tfpf_dp.sv
// Filter datapath: product stage, grouped partial sums, rounding and saturation.
module tfpf_dp #(
    parameter int TAPS = 20,
    localparam int HIST = TAPS - 1
) (
    input  logic              aclk,
    input  logic              adv,
    input  tfpf_pkg::sample_t sample,
    input  tfpf_pkg::sample_t hist [HIST],
    output tfpf_pkg::sample_t filtered,
    output logic              clipped
);
    import tfpf_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(TAPS);
    localparam int NGRP  = (TAPS + GRP - 1) / GRP;
    localparam int RES_W = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32'sd32767);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-32'sd32768);
    localparam sample_t OUT_MAX = 16'sh7FFF;
    localparam sample_t OUT_MIN = -16'sh8000;

    prod_t                    prod_reg [TAPS];
    logic signed [ACC_W-1:0]  part_next [NGRP];
    logic signed [ACC_W-1:0]  part_reg [NGRP];
    logic signed [ACC_W-1:0]  sum;
    logic signed [RES_W-1:0]  res;

    for (genvar k = 0; k < TAPS; k++) begin : g_mul
        localparam coef_t C = coef_at(k, TAPS);
        if (k == 0) begin : g_cur
            always_ff @(posedge aclk) begin
                if (adv) begin
                    prod_reg[k] <= C * sample;
                end
            end
        end else begin : g_past
            always_ff @(posedge aclk) begin
                if (adv) begin
                    prod_reg[k] <= C * hist[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            part_next[g] = '0;
            for (int i = 0; i < GRP; i++) begin
                if (g * GRP + i < TAPS) begin
                    part_next[g] = part_next[g] + ACC_W'(prod_reg[g * GRP + i]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            part_reg <= part_next;
        end
    end

    // Round half up, floor shift, saturate
    always_comb begin
        sum = ROUND;
        for (int g = 0; g < NGRP; g++) begin
            sum = sum + part_reg[g];
        end
        res = sum[ACC_W-1:FRAC_W];
        if (res > RES_MAX) begin
            filtered = OUT_MAX;
            clipped  = 1'b1;
        end else if (res < RES_MIN) begin
            filtered = OUT_MIN;
            clipped  = 1'b1;
        end else begin
            filtered = res[SAMPLE_W-1:0];
            clipped  = 1'b0;
        end
    end

endmodule

>>> design/temporal_fir_pixel_filter.sv
// Pipeline: each result passes through the s1, s2 and s3 registers to the output register, all held while it stalls.
// Throughput: one sample per cycle while the output is not stalled and the sweep is done; the history RAMs are
// read and rewritten for each accepted sample. Reset: synchronous, active low; clears control state and then
// sweeps all MAX_PIXELS positions (1024 by default) of the history RAMs to zero with s_axis_tready low.
// Configuration writes are taken during the sweep.
module temporal_fir_pixel_filter #(
    parameter int TAPS       = tfpf_pkg::TAPS_DEF,
    parameter int MAX_PIXELS = tfpf_pkg::MAX_PIXELS_DEF,
    localparam int POS_W     = $clog2(MAX_PIXELS),
    localparam int M_TDATA_W = ((tfpf_pkg::SAMPLE_W + POS_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tfpf_pkg::FP_W-1:0]      cfg_wr_data,    // frame_pixels
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tfpf_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic [0:0]                     s_axis_tuser,   // [0] frame_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [M_TDATA_W-1:0]           m_axis_tdata,   // filtered, pixel_position, zero pad
    output logic [tfpf_pkg::USER_W-1:0]    m_axis_tuser    // [0] window_full, [1] clipped
);
    import tfpf_pkg::*;

    localparam int HIST  = TAPS - 1;
    localparam int FS_W  = $clog2(TAPS);
    localparam int CMP_W = (POS_W + 1 > FP_W) ? POS_W + 1 : FP_W;
    localparam int PAD_W = M_TDATA_W - SAMPLE_W - POS_W;

    logic [FP_W-1:0]  frame_pixels_reg;
    logic [POS_W-1:0] pix_cnt_reg;
    logic [FS_W-1:0]  frames_seen_reg;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    sample_t          s1_sample_reg;
    logic [POS_W-1:0] s1_pos_reg, s2_pos_reg, s3_pos_reg, m_pos_reg;
    logic             s1_full_reg, s2_full_reg, s3_full_reg, m_full_reg;
    sample_t          m_filtered_reg;
    logic             m_clip_reg;

    logic             adv, accept, busy, wrap, full;
    logic [CMP_W-1:0] fp_ext, fp_eff;
    logic [POS_W-1:0] pos_raw, pos;
    sample_t          hist [HIST];
    sample_t          filtered;
    logic             clipped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FP_W'(FP_RESET);
        end else if (cfg_wr_en) begin
            frame_pixels_reg <= cfg_wr_data;
        end
    end

    // Whole pipeline moves when the output register is free or being drained
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy && adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Position of this sample within the frame
    always_comb begin
        fp_ext = CMP_W'(frame_pixels_reg);
        if (fp_ext == '0) begin
            fp_eff = CMP_W'(1);
        end else if (fp_ext > CMP_W'(MAX_PIXELS)) begin
            fp_eff = CMP_W'(MAX_PIXELS);
        end else begin
            fp_eff = fp_ext;
        end
        pos_raw = s_axis_tuser[0] ? '0 : pix_cnt_reg;
        pos     = (CMP_W'(pos_raw) >= fp_eff) ? '0 : pos_raw;
        wrap    = (CMP_W'(pos) + CMP_W'(1)) >= fp_eff;
        full    = frames_seen_reg == FS_W'(HIST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg     <= '0;
            frames_seen_reg <= '0;
        end else if (accept) begin
            if (wrap) begin
                pix_cnt_reg <= '0;
                if (!full) begin
                    frames_seen_reg <= frames_seen_reg + FS_W'(1);
                end
            end else begin
                pix_cnt_reg <= pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sample_reg  <= s_axis_tdata;
            s1_pos_reg     <= pos;
            s1_full_reg    <= full;
            s2_pos_reg     <= s1_pos_reg;
            s2_full_reg    <= s1_full_reg;
            s3_pos_reg     <= s2_pos_reg;
            s3_full_reg    <= s2_full_reg;
            m_pos_reg      <= s3_pos_reg;
            m_full_reg     <= s3_full_reg;
            m_filtered_reg <= filtered;
            m_clip_reg     <= clipped;
        end
    end

    tfpf_store #(
        .TAPS       (TAPS),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (pos),
        .wr_en     (adv && s1_valid_reg),
        .wr_addr   (s1_pos_reg),
        .wr_sample (s1_sample_reg),
        .hist      (hist),
        .busy      (busy)
    );

    tfpf_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .aclk     (aclk),
        .adv      (adv),
        .sample   (s1_sample_reg),
        .hist     (hist),
        .filtered (filtered),
        .clipped  (clipped)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), m_pos_reg, m_filtered_reg};
    always_comb begin
        m_axis_tuser                = '0;
        m_axis_tuser[USER_FULL_BIT] = m_full_reg;
        m_axis_tuser[USER_CLIP_BIT] = m_clip_reg;
    end

endmodule

>>> design/tfpf_checker.sv
// Port-level checks for the temporal FIR pixel filter, bound to the top level.
module tfpf_checker #(
    parameter int M_TDATA_W = 32
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [M_TDATA_W-1:0]        m_axis_tdata,
    input logic [tfpf_pkg::USER_W-1:0] m_axis_tuser
);
    import tfpf_pkg::*;

    // Reset empties the output and starts the clearing sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input ready or output valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_CLIP_BIT] |->
            m_axis_tdata[SAMPLE_W-1:0] == 16'h7FFF ||
            m_axis_tdata[SAMPLE_W-1:0] == 16'h8000)
        else $error("clipped result not at a rail");

    // Frame count saturates, so the full window never drops without reset
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_FULL_BIT] |=>
            !m_axis_tvalid || m_axis_tuser[USER_FULL_BIT])
        else $error("window_full dropped");

endmodule

bind temporal_fir_pixel_filter tfpf_checker #(.M_TDATA_W(M_TDATA_W)) u_checker (.*);

>>> bench/temporal_fir_pixel_filter_tb.sv
// Self-checking stream testbench for the temporal FIR pixel filter.
`timescale 1ns / 1ps

module temporal_fir_pixel_filter_tb;

    import tfpf_pkg::*;

    localparam int MAX_PIX   = MAX_PIXELS_DEF;
    localparam int HIST_LEN  = TAPS_DEF - 1;
    localparam int POS_BITS  = $clog2(MAX_PIX);
    localparam int RUN_LIMIT = 400000;

    // Q1.15 weights of the first half of the impulse response
    localparam int HALF_WEIGHT [HALF_LEN] = '{
        331, -174, -1003, -524, 2100, 2920, -1429, -5521, -1914, 5295
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic [POS_BITS-1:0]        pos;
        logic                       full;
        logic                       clip;
    } pix_result_t;

    typedef struct {
        bit                  wr_cfg;   // drain, then write frame size before this transfer
        logic [FP_W-1:0]     fp;
        logic [SAMPLE_W-1:0] smp;
        logic                fs;
        bit                  typed;    // use the result given here
        pix_result_t         want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [FP_W-1:0]       cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample
    logic [0:0]            s_axis_tuser;   // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // [15:0] filtered, [25:16] pixel_position, zero pad
    logic [USER_W-1:0]     m_axis_tuser;   // [0] window_full, [1] clipped

    // Filter state as seen from outside
    bit signed [SAMPLE_W-1:0] pix_hist [MAX_PIX][HIST_LEN];
    int unsigned pixel_ctr   = 0;
    int unsigned frames_seen = 0;
    int unsigned frame_size  = FP_RESET;

    pix_result_t expected_pixels [$];
    int          n_errors = 0;
    bit          snd_idle = 1'b0;
    int unsigned cycle_count = 0;

    dir_row_t dir_rows [14] = '{
        '{1'b0, 11'd0,    16'h7fff, 1'b0, 1'b1, {16'sd331, 10'd0, 1'b0, 1'b0}},
        '{1'b0, 11'd0,    16'h8000, 1'b0, 1'b1, {-16'sd331, 10'd1, 1'b0, 1'b0}},
        '{1'b0, 11'd0,    16'h0000, 1'b0, 1'b1, {16'sd0, 10'd2, 1'b0, 1'b0}},
        '{1'b0, 11'd0,    16'h0001, 1'b1, 1'b0, '0},
        '{1'b0, 11'd0,    16'hffff, 1'b0, 1'b0, '0},
        '{1'b1, 11'd2047, 16'h8000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd2,    16'h7fff, 1'b0, 1'b0, '0},
        '{1'b0, 11'd0,    16'h8001, 1'b0, 1'b0, '0},
        '{1'b1, 11'd0,    16'h4000, 1'b0, 1'b0, '0},
        '{1'b0, 11'd0,    16'hc000, 1'b1, 1'b0, '0},
        '{1'b0, 11'd0,    16'h7fff, 1'b0, 1'b0, '0},
        '{1'b1, 11'd1024, 16'h5a5a, 1'b0, 1'b0, '0},
        '{1'b0, 11'd0,    16'ha5a5, 1'b1, 1'b0, '0},
        '{1'b1, 11'd1,    16'h0000, 1'b1, 1'b0, '0}
    };

    temporal_fir_pixel_filter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int tap_weight(input int k);
        int m;
        m = HIST_LEN - k;
        if (k < m) begin
            m = k;
        end
        return (m < HALF_LEN) ? HALF_WEIGHT[m] : 0;
    endfunction

    function automatic int effective_frame_size();
        if (frame_size == 0) begin
            return 1;
        end
        return (frame_size > MAX_PIX) ? MAX_PIX : frame_size;
    endfunction

    function automatic int next_position();
        return (pixel_ctr >= effective_frame_size()) ? 0 : pixel_ctr;
    endfunction

    // Filter one pixel and advance the history and frame counters
    function automatic pix_result_t filter_pixel(input logic [SAMPLE_W-1:0] raw, input logic fs);
        int          pos;
        int          j;
        longint      acc;
        longint      v;
        pix_result_t r;
        pos = fs ? 0 : next_position();
        acc = longint'(tap_weight(0)) * longint'($signed(raw));
        for (j = 0; j < HIST_LEN; j++) begin
            acc += longint'(tap_weight(j + 1)) * longint'(pix_hist[pos][j]);
        end
        // round half up, floor shift
        v = (acc + 64'sd16384) >>> FRAC_W;
        r.clip = 1'b1;
        if (v > 32767) begin
            r.filtered = 16'sh7fff;
        end else if (v < -32768) begin
            r.filtered = 16'sh8000;
        end else begin
            r.filtered = v[SAMPLE_W-1:0];
            r.clip     = 1'b0;
        end
        r.pos  = POS_BITS'(pos);
        r.full = (frames_seen >= HIST_LEN);
        for (j = HIST_LEN - 1; j > 0; j--) begin
            pix_hist[pos][j] = pix_hist[pos][j-1];
        end
        pix_hist[pos][0] = raw;
        if (pos + 1 >= effective_frame_size()) begin
            pixel_ctr = 0;
            if (frames_seen < HIST_LEN) begin
                frames_seen++;
            end
        end else begin
            pixel_ctr = pos + 1;
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_pixel(input logic [SAMPLE_W-1:0] smp, input logic fs, input bit typed,
                              input pix_result_t typed_want);
        int          gap;
        pix_result_t r;
        gap = snd_idle ? $urandom_range(0, 18) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= fs;
        do @(posedge aclk); while (!s_axis_tready);
        r = filter_pixel(smp, fs);
        expected_pixels.push_back(typed ? typed_want : r);
    endtask

    // Hold the input idle until every pending result has come out
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_frame_size(input logic [FP_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        frame_size = v;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result side: random stalls, one long hold-off, compare against the oldest expectation
    initial begin : result_checker
        int          stall;
        int          n_res;
        bit          rcv_idle;
        pix_result_t got;
        pix_result_t want;
        n_res    = 0;
        rcv_idle = 1'b1;
        m_axis_tready = 1'b0;
        forever begin
            stall = (n_res == 200) ? 500 : (rcv_idle ? $urandom_range(0, 18) : 0);
            @(negedge aclk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got = {m_axis_tdata[SAMPLE_W-1:0], m_axis_tdata[SAMPLE_W +: POS_BITS],
                   m_axis_tuser[USER_FULL_BIT], m_axis_tuser[USER_CLIP_BIT]};
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none got %h", $time, got);
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("filtered", int'(want.filtered), int'(got.filtered));
                check_field("pixel_position", int'(want.pos), int'(got.pos));
                check_field("window_full", int'(want.full), int'(got.full));
                check_field("clipped", int'(want.clip), int'(got.clip));
            end
            n_res++;
            if (n_res % 64 == 0) begin
                rcv_idle = ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial begin : stimulus
        int              n_items;
        int              count;
        int              i;
        int              t;
        int              p;
        int              mag;
        int              burst_fp;
        bit              pol;
        logic [FP_W-1:0] fsz;
        logic            fs;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].wr_cfg) begin
                write_frame_size(dir_rows[k].fp);
            end
            send_pixel(dir_rows[k].smp, dir_rows[k].fs, dir_rows[k].typed, dir_rows[k].want);
        end

        // One full-size frame plus a wrap, sent back to back
        write_frame_size(11'd2047);
        snd_idle = 1'b0;
        for (i = 0; i < MAX_PIX + 2; i++) begin
            send_pixel(pick_sample(), i == 0, 1'b0, '0);
        end

        n_items = 0;
        while (n_items < 450) begin
            snd_idle = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // Twenty frames signed to match the taps: drive the sum into saturation
                burst_fp = $urandom_range(1, 3);
                write_frame_size(FP_W'(burst_fp));
                pol = $urandom_range(0, 1);
                for (t = 0; t < TAPS_DEF; t++) begin
                    for (p = 0; p < burst_fp; p++) begin
                        mag = $urandom_range(32000, 32768);
                        if ((tap_weight(t) < 0) ^ pol) begin
                            send_pixel(16'(-mag), p == 0, 1'b0, '0);
                        end else begin
                            send_pixel(16'(mag > 32767 ? 32767 : mag), p == 0, 1'b0, '0);
                        end
                        n_items++;
                    end
                end
            end else begin
                case ($urandom_range(0, 15))
                    0: fsz = 11'd0;
                    1: fsz = 11'd1;
                    2: fsz = 11'd1024;
                    3: fsz = 11'd2047;
                    4: fsz = FP_W'($urandom_range(0, 2047));
                    default: fsz = FP_W'($urandom_range(2, 12));
                endcase
                write_frame_size(fsz);
                count = $urandom_range(20, 120);
                for (i = 0; i < count; i++) begin
                    // mostly mark frame heads, now and then break a frame early
                    if (next_position() == 0) begin
                        fs = ($urandom_range(0, 3) != 0);
                    end else begin
                        fs = ($urandom_range(0, 23) == 0);
                    end
                    send_pixel(pick_sample(), fs, 1'b0, '0);
                    n_items++;
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/tfpf_pkg.sv
design/tfpf_ram.sv
design/tfpf_store.sv
design/tfpf_dp.sv
design/temporal_fir_pixel_filter.sv
design/tfpf_checker.sv
bench/temporal_fir_pixel_filter_tb.sv
